>>> src/hsck_pkg.sv
// ----------------------------------------------------------------------------
// hsck_pkg
// Shared constants and types for the hue/saturation colour key.
// ----------------------------------------------------------------------------
package hsck_pkg;

	// Fixed-point fraction of the reciprocal tables.
	localparam int unsigned FRAC_BITS = 12;

	// Reciprocal table numerators and widths.
	localparam int unsigned SAT_NUM = 255 << FRAC_BITS;
	localparam int unsigned HUE_NUM = 30 << FRAC_BITS;
	localparam int unsigned SDIV_W  = 20;
	localparam int unsigned HDIV_W  = 17;

	// Width of the signed hue numerator (covers -255..1275).
	localparam int unsigned HNUM_W = 12;

	// Full hue circle in units of two degrees.
	localparam logic [7:0] HUE_WRAP = 8'd180;

	// Queue between the front and back parts.
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_MIN_HUE = 2'd0;
	localparam logic [1:0] REG_MAX_HUE = 2'd1;
	localparam logic [1:0] REG_MIN_SAT = 2'd2;
	localparam logic [1:0] REG_MAX_SAT = 2'd3;

	// Register reset values.
	localparam logic [7:0] RST_MIN_HUE = 8'd15;
	localparam logic [7:0] RST_MAX_HUE = 8'd40;
	localparam logic [7:0] RST_MIN_SAT = 8'd120;
	localparam logic [7:0] RST_MAX_SAT = 8'd255;

	// Key thresholds handed to the back part.
	typedef struct packed {
		logic [7:0] min_hue;
		logic [7:0] max_hue;
		logic [7:0] min_sat;
		logic [7:0] max_sat;
	} cfg_t;

	// One classified pixel as it waits in the queue.
	typedef struct packed {
		logic [7:0]               blue;
		logic [7:0]               green;
		logic [7:0]               red;
		logic [7:0]               vmax;
		logic [7:0]               diff;
		logic signed [HNUM_W-1:0] hnum;
		logic [SDIV_W-1:0]        sdiv;
		logic [HDIV_W-1:0]        hdiv;
	} item_t;

endpackage

>>> src/hsck_front.sv
// ----------------------------------------------------------------------------
// hsck_front
// Accepts pixels, finds max/min and the hue sector, then looks up the
// reciprocals of the maximum and of the spread.
// ----------------------------------------------------------------------------
module hsck_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_blue,
	input  logic [7:0]          in_green,
	input  logic [7:0]          in_red,
	output logic                out_valid,
	input  logic                out_ready,
	output hsck_pkg::item_t     out_item
);

	// Constant reciprocal tables, rounded half to even, built at elaboration.
	logic [hsck_pkg::SDIV_W-1:0] sdiv_tab [256];
	logic [hsck_pkg::HDIV_W-1:0] hdiv_tab [256];

	for (genvar i = 0; i < 256; i++) begin : g_tab
		localparam int unsigned DEN = (i == 0) ? 1 : i;
		localparam int unsigned SQ  = hsck_pkg::SAT_NUM / DEN;
		localparam int unsigned SR  = hsck_pkg::SAT_NUM % DEN;
		localparam int unsigned HQ  = hsck_pkg::HUE_NUM / DEN;
		localparam int unsigned HR  = hsck_pkg::HUE_NUM % DEN;
		localparam int unsigned SRND = (i == 0) ? 0 :
			SQ + (((2 * SR > DEN) || ((2 * SR == DEN) && (SQ % 2 == 1))) ? 1 : 0);
		localparam int unsigned HRND = (i == 0) ? 0 :
			HQ + (((2 * HR > DEN) || ((2 * HR == DEN) && (HQ % 2 == 1))) ? 1 : 0);
		assign sdiv_tab[i] = hsck_pkg::SDIV_W'(SRND);
		assign hdiv_tab[i] = hsck_pkg::HDIV_W'(HRND);
	end

	// Stage handshakes.
	logic valid_s1, valid_s2;
	logic ready_s1, ready_s2;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// Maximum, minimum and hue numerator of the incoming pixel.
	logic [7:0]                         vmax_w, vmin_w, diff_w;
	logic signed [hsck_pkg::HNUM_W-1:0] bs, gs, rs, ds, hnum_w;

	always_comb begin
		vmax_w = in_blue;
		vmin_w = in_blue;
		if (in_green > vmax_w) vmax_w = in_green;
		if (in_red > vmax_w) vmax_w = in_red;
		if (in_green < vmin_w) vmin_w = in_green;
		if (in_red < vmin_w) vmin_w = in_red;
		diff_w = vmax_w - vmin_w;
		bs = $signed({4'b0, in_blue});
		gs = $signed({4'b0, in_green});
		rs = $signed({4'b0, in_red});
		ds = $signed({4'b0, diff_w});
		// Red wins a tie for the maximum, then green.
		if (vmax_w == in_red) begin
			hnum_w = gs - bs;
		end else if (vmax_w == in_green) begin
			hnum_w = bs - rs + (ds <<< 1);
		end else begin
			hnum_w = rs - gs + (ds <<< 2);
		end
	end

	// Stage 1 registers.
	logic [7:0]                         blue_s1, green_s1, red_s1, vmax_s1, diff_s1;
	logic signed [hsck_pkg::HNUM_W-1:0] hnum_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			blue_s1  <= in_blue;
			green_s1 <= in_green;
			red_s1   <= in_red;
			vmax_s1  <= vmax_w;
			diff_s1  <= diff_w;
			hnum_s1  <= hnum_w;
		end
	end

	// Stage 2: table lookups.
	hsck_pkg::item_t item_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			item_s2.blue  <= blue_s1;
			item_s2.green <= green_s1;
			item_s2.red   <= red_s1;
			item_s2.vmax  <= vmax_s1;
			item_s2.diff  <= diff_s1;
			item_s2.hnum  <= hnum_s1;
			item_s2.sdiv  <= sdiv_tab[vmax_s1];
			item_s2.hdiv  <= hdiv_tab[diff_s1];
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

endmodule

>>> src/hsck_fifo.sv
// ----------------------------------------------------------------------------
// hsck_fifo
// Short queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module hsck_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  hsck_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop_ready,
	output hsck_pkg::item_t pop_item
);

	hsck_pkg::item_t              mem_q [hsck_pkg::FIFO_DEPTH];
	logic [hsck_pkg::FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [hsck_pkg::FIFO_AW:0]   count_q;
	logic                         do_push, do_pop;

	assign push_ready = (count_q != (hsck_pkg::FIFO_AW + 1)'(hsck_pkg::FIFO_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> src/hsck_back.sv
// ----------------------------------------------------------------------------
// hsck_back
// Multiplies by the reciprocals, rounds hue and saturation, applies the key
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module hsck_back (
	input  logic            clk,
	input  logic            arst_n,
	input  hsck_pkg::cfg_t  cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  hsck_pkg::item_t in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            out_key_hit,
	output logic [7:0]      out_hue,
	output logic [7:0]      out_sat,
	output logic [7:0]      out_bright,
	output logic [7:0]      out_blue,
	output logic [7:0]      out_green,
	output logic [7:0]      out_red
);

	localparam int unsigned SPROD_W = 8 + hsck_pkg::SDIV_W;
	localparam int unsigned HPROD_W = hsck_pkg::HNUM_W + hsck_pkg::HDIV_W + 1;

	logic valid_s3, valid_s4;
	logic ready_s3, ready_s4;

	assign ready_s4 = !valid_s4 || out_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign in_ready = ready_s3;

	// Stage 3: the two products.
	logic [SPROD_W-1:0]        sprod_s3;
	logic signed [HPROD_W-1:0] hprod_s3;
	logic [7:0]                blue_s3, green_s3, red_s3, vmax_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && in_valid) begin
			sprod_s3 <= SPROD_W'(in_item.diff) * SPROD_W'(in_item.sdiv);
			hprod_s3 <= HPROD_W'(in_item.hnum) * HPROD_W'($signed({1'b0, in_item.hdiv}));
			blue_s3  <= in_item.blue;
			green_s3 <= in_item.green;
			red_s3   <= in_item.red;
			vmax_s3  <= in_item.vmax;
		end
	end

	// Rounding to nearest, with negative hues folded onto the circle.
	logic signed [HPROD_W-1:0] hround;
	logic [SPROD_W-1:0]        sround;
	logic [7:0]                hue_w, sat_w;
	logic                      below, above, hue_ok, sat_ok, hit_w;

	always_comb begin
		hround = (hprod_s3 + HPROD_W'(1 << (hsck_pkg::FRAC_BITS - 1)))
			>>> hsck_pkg::FRAC_BITS;
		sround = (sprod_s3 + SPROD_W'(1 << (hsck_pkg::FRAC_BITS - 1)))
			>> hsck_pkg::FRAC_BITS;
		hue_w = hround[HPROD_W-1] ? (hround[7:0] + hsck_pkg::HUE_WRAP) : hround[7:0];
		sat_w = sround[7:0];
		// An ordered pair of bounds needs both tests, otherwise the range wraps.
		below  = (hue_w <= cfg.max_hue);
		above  = (hue_w > cfg.min_hue);
		hue_ok = (cfg.min_hue < cfg.max_hue) ? (below && above) : (below || above);
		sat_ok = (sat_w >= cfg.min_sat) && (sat_w <= cfg.max_sat);
		hit_w  = hue_ok && sat_ok;
	end

	// Stage 4: output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ready_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			out_key_hit <= hit_w;
			out_hue     <= hue_w;
			out_sat     <= sat_w;
			out_bright  <= vmax_s3;
			out_blue    <= hit_w ? blue_s3 : 8'd0;
			out_green   <= hit_w ? green_s3 : 8'd0;
			out_red     <= hit_w ? red_s3 : 8'd0;
		end
	end

	assign out_valid = valid_s4;

endmodule

>>> src/hue_saturation_color_key_top.sv
// ----------------------------------------------------------------------------
// hue_saturation_color_key_top
// HSV colour key: converts a BGR pixel to 8-bit HSV and keys it on hue and
// saturation ranges.
//
// Channel       Direction  Payload
// s_axis_*      in         tdata: blue[7:0] green[15:8] red[23:16]
// m_axis_*      out        tdata: hue, saturation, brightness, out_blue,
//                          out_green, out_red; tuser: key_hit
// APB           in/out     min_hue 0x0, max_hue 0x4, min_sat 0x8, max_sat 0xC
//
// One pixel per cycle is accepted and delivered when nothing stalls; an input
// transaction passes through both front stages, the queue and both back stages.
// The two front stages (compare, table lookup) and the two back stages
// (multiply, round and key) are separated by a four-entry queue, so a stall
// on the output fills the queue before the input stops accepting.
// Reset is asynchronous; no clearing pass is needed afterwards.
// ----------------------------------------------------------------------------
module hue_saturation_color_key_top (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // blue[7:0], green[15:8], red[23:16]
	// Output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // hue[7:0], saturation[15:8], brightness[23:16],
	                                   // out_blue[31:24], out_green[39:32], out_red[47:40]
	output logic [0:0]  m_axis_tuser,  // key_hit[0]
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Configuration registers.
	hsck_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [1:0]     reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_hue <= hsck_pkg::RST_MIN_HUE;
			cfg_q.max_hue <= hsck_pkg::RST_MAX_HUE;
			cfg_q.min_sat <= hsck_pkg::RST_MIN_SAT;
			cfg_q.max_sat <= hsck_pkg::RST_MAX_SAT;
		end else if (wr_en) begin
			case (reg_idx)
				hsck_pkg::REG_MIN_HUE: cfg_q.min_hue <= pwdata[7:0];
				hsck_pkg::REG_MAX_HUE: cfg_q.max_hue <= pwdata[7:0];
				hsck_pkg::REG_MIN_SAT: cfg_q.min_sat <= pwdata[7:0];
				hsck_pkg::REG_MAX_SAT: cfg_q.max_sat <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (reg_idx)
			hsck_pkg::REG_MIN_HUE: prdata = {24'd0, cfg_q.min_hue};
			hsck_pkg::REG_MAX_HUE: prdata = {24'd0, cfg_q.max_hue};
			hsck_pkg::REG_MIN_SAT: prdata = {24'd0, cfg_q.min_sat};
			hsck_pkg::REG_MAX_SAT: prdata = {24'd0, cfg_q.max_sat};
			default:               prdata = 32'd0;
		endcase
	end

	// Front part.
	logic            front_valid, front_ready;
	hsck_pkg::item_t front_item;

	hsck_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_blue   (s_axis_tdata[7:0]),
		.in_green  (s_axis_tdata[15:8]),
		.in_red    (s_axis_tdata[23:16]),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_item  (front_item)
	);

	// Queue between the parts.
	logic            back_valid, back_ready;
	hsck_pkg::item_t back_item;

	hsck_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_item  (front_item),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_item   (back_item)
	);

	// Back part.
	hsck_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (back_valid),
		.in_ready    (back_ready),
		.in_item     (back_item),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_key_hit (m_axis_tuser[0]),
		.out_hue     (m_axis_tdata[7:0]),
		.out_sat     (m_axis_tdata[15:8]),
		.out_bright  (m_axis_tdata[23:16]),
		.out_blue    (m_axis_tdata[31:24]),
		.out_green   (m_axis_tdata[39:32]),
		.out_red     (m_axis_tdata[47:40])
	);

endmodule

>>> src/hsck_checker.sv
// ----------------------------------------------------------------------------
// hsck_checker
// Port-level checks on the output stream of the colour key.
// ----------------------------------------------------------------------------
module hsck_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [47:0] m_axis_tdata,
	input  logic [0:0]  m_axis_tuser
);

	// A stalled output transaction stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output valid dropped while stalled");

	// A missed key always carries a black pixel.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[47:24] == 24'd0)
		else $error("pixel not zeroed on key miss");

	// Hue stays below a full circle.
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[7:0] < 8'd180)
		else $error("hue out of range");

	// A black pixel has no saturation.
	a_black_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[23:16] == 8'd0 |-> m_axis_tdata[15:8] == 8'd0)
		else $error("saturation nonzero on black pixel");

endmodule

bind hue_saturation_color_key_top hsck_checker u_hsck_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the hue/saturation colour key. Pixels stream
// in under random idling on both sides while the key thresholds are changed
// between phases over the configuration port. A scoreboard predicts every
// HSV conversion and key decision and compares each output transaction with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb;

	// One predicted output transaction.
	typedef struct packed {
		logic       key_hit;
		logic [7:0] hue;
		logic [7:0] saturation;
		logic [7:0] brightness;
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
	} key_result_t;

	// Scoreboard: keeps its own copy of the thresholds and the queue of
	// predicted results in arrival order.
	class color_key_board;
		logic [7:0]  min_hue;
		logic [7:0]  max_hue;
		logic [7:0]  min_sat;
		logic [7:0]  max_sat;
		key_result_t predicted_q[$];
		int          errors;

		function new();
			min_hue = hsck_pkg::RST_MIN_HUE;
			max_hue = hsck_pkg::RST_MAX_HUE;
			min_sat = hsck_pkg::RST_MIN_SAT;
			max_sat = hsck_pkg::RST_MAX_SAT;
			errors  = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [7:0] val);
			case (idx)
				hsck_pkg::REG_MIN_HUE: min_hue = val;
				hsck_pkg::REG_MAX_HUE: max_hue = val;
				hsck_pkg::REG_MIN_SAT: min_sat = val;
				hsck_pkg::REG_MAX_SAT: max_sat = val;
				default: ;
			endcase
		endfunction

		function int pending();
			return predicted_q.size();
		endfunction

		// Division rounded to nearest, ties going to the even quotient.
		function int unsigned recip(int unsigned num, int unsigned den);
			int unsigned q;
			int unsigned r;
			q = num / den;
			r = num % den;
			if (2 * r > den || (2 * r == den && q[0]))
				q++;
			return q;
		endfunction

		// Converts an accepted pixel and queues the expected result.
		function void note_pixel(logic [23:0] px);
			int          b, g, r, v, vmin, diff, hnum, h, s;
			int unsigned sdiv, hdiv;
			longint      prod;
			bit          below, above, hue_ok, sat_ok, hit;
			key_result_t res;
			b = px[7:0];
			g = px[15:8];
			r = px[23:16];
			v = b;
			vmin = b;
			if (g > v) v = g;
			if (r > v) v = r;
			if (g < vmin) vmin = g;
			if (r < vmin) vmin = r;
			diff = v - vmin;
			sdiv = (v == 0) ? 0 : recip(255 << hsck_pkg::FRAC_BITS, v);
			hdiv = (diff == 0) ? 0 : recip(30 << hsck_pkg::FRAC_BITS, diff);
			s = (diff * int'(sdiv) + (1 << (hsck_pkg::FRAC_BITS - 1)))
				>>> hsck_pkg::FRAC_BITS;
			// Red wins a tie for the maximum, then green.
			if (v == r)
				hnum = g - b;
			else if (v == g)
				hnum = b - r + 2 * diff;
			else
				hnum = r - g + 4 * diff;
			prod = longint'(hnum) * longint'(hdiv) + (1 << (hsck_pkg::FRAC_BITS - 1));
			h = int'(prod >>> hsck_pkg::FRAC_BITS);
			if (h < 0)
				h += 180;
			// Bounds in the wrong order give a range that wraps round.
			below = h <= int'(max_hue);
			above = h > int'(min_hue);
			hue_ok = (min_hue < max_hue) ? (below && above) : (below || above);
			sat_ok = s >= int'(min_sat) && s <= int'(max_sat);
			hit = hue_ok && sat_ok;
			res.key_hit    = hit;
			res.hue        = h[7:0];
			res.saturation = s[7:0];
			res.brightness = v[7:0];
			res.out_blue   = hit ? px[7:0] : 8'd0;
			res.out_green  = hit ? px[15:8] : 8'd0;
			res.out_red    = hit ? px[23:16] : 8'd0;
			predicted_q.insert(predicted_q.size(), res);
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want,
					got);
			end
		endfunction

		// Checks one output transaction against the oldest prediction.
		function void check_result(logic [47:0] data, logic key);
			key_result_t want;
			if (predicted_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual key %0b data %h",
					$time, key, data);
				return;
			end
			want = predicted_q.pop_front();
			compare_field("key_hit", want.key_hit, key);
			compare_field("hue", want.hue, data[7:0]);
			compare_field("saturation", want.saturation, data[15:8]);
			compare_field("brightness", want.brightness, data[23:16]);
			compare_field("out_blue", want.out_blue, data[31:24]);
			compare_field("out_green", want.out_green, data[39:32]);
			compare_field("out_red", want.out_red, data[47:40]);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	bit             idle_en = 1'b1;
	color_key_board board;

	hue_saturation_color_key_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// Clock, period of 8.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver backpressure: while idling is enabled, stalls about ten percent of the time.
	always @(posedge clk) begin
		m_axis_tready <= idle_en ? ($urandom_range(0, 99) >= 10) : 1'b1;
	end

	// Output monitor: every accepted result goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_result(m_axis_tdata, m_axis_tuser[0]);
	end

	// Safety net against a hung handshake.
	initial begin
		#(1_600_000);
		$display("tb failed");
		$finish;
	end

	function automatic logic [23:0] bgr(int b, int g, int r);
		return {r[7:0], g[7:0], b[7:0]};
	endfunction

	// Random pixel with a bias towards greys, ties, dark and vivid colours.
	function automatic logic [23:0] random_pixel();
		int hi, lo, c;
		hi = $urandom_range(1, 255);
		lo = $urandom_range(0, hi - 1);
		c = $urandom_range(0, 255);
		case ($urandom_range(0, 9))
			0: return bgr(c, c, c);
			1: case ($urandom_range(0, 2))
				0: return bgr(lo, hi, hi);
				1: return bgr(hi, hi, lo);
				default: return bgr(hi, lo, hi);
			endcase
			2: return bgr($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7));
			3: case ($urandom_range(0, 2))
				0: return bgr(0, c, 255);
				1: return bgr(255, 0, c);
				default: return bgr(c, 255, 0);
			endcase
			default: return 24'($urandom);
		endcase
	endfunction

	// Sends one pixel, with an occasional gap first, and waits for the
	// input transaction.
	task automatic send_pixel(logic [23:0] px);
		if (idle_en && $urandom_range(0, 99) < 8) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		board.note_pixel(px);
	endtask

	// Waits until every queued result has come out and the pipeline is empty.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		board.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic set_keys(int min_h, int max_h, int min_s, int max_s);
		drain();
		write_reg(hsck_pkg::REG_MIN_HUE, min_h[7:0]);
		write_reg(hsck_pkg::REG_MAX_HUE, max_h[7:0]);
		write_reg(hsck_pkg::REG_MIN_SAT, min_s[7:0]);
		write_reg(hsck_pkg::REG_MAX_SAT, max_s[7:0]);
	endtask

	// Main sequence.
	initial begin
		int min_h, max_h, min_s, max_s;
		board = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pixels under the reset thresholds.
		send_pixel(bgr(0, 0, 0));
		send_pixel(bgr(255, 255, 255));
		send_pixel(bgr(128, 128, 128));
		send_pixel(bgr(1, 1, 1));
		send_pixel(bgr(0, 0, 255));
		send_pixel(bgr(0, 255, 0));
		send_pixel(bgr(255, 0, 0));
		send_pixel(bgr(0, 255, 255));
		send_pixel(bgr(255, 255, 0));
		send_pixel(bgr(255, 0, 255));
		send_pixel(bgr(1, 0, 255));
		send_pixel(bgr(0, 1, 255));
		send_pixel(bgr(0, 0, 1));
		send_pixel(bgr(0, 128, 255));
		send_pixel(bgr(0, 64, 255));
		send_pixel(bgr(100, 100, 200));
		send_pixel(bgr(254, 255, 255));
		send_pixel(bgr(255, 254, 255));
		send_pixel(bgr(0, 160, 255));
		send_pixel(bgr(40, 210, 230));

		// Random phases; the first few use extreme thresholds.
		for (int phase = 0; phase < 12; phase++) begin
			case (phase)
				0: set_keys(0, 180, 0, 255);
				1: set_keys(170, 10, 50, 200);
				2: set_keys(90, 90, 0, 255);
				3: set_keys(255, 255, 255, 255);
				4: set_keys(0, 0, 0, 0);
				5: set_keys(20, 255, 128, 128);
				default: begin
					min_h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
						: $urandom_range(0, 180);
					max_h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
						: $urandom_range(0, 180);
					min_s = $urandom_range(0, 255);
					max_s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
						: $urandom_range(min_s, 255);
					set_keys(min_h, max_h, min_s, max_s);
				end
			endcase
			// One long stretch runs without any idling on either side.
			idle_en = (phase != 2);
			for (int n = 0; n < 125; n++) begin
				// Halfway through one phase the sender holds off until
				// everything has come out.
				if (phase == 4 && n == 60) begin
					s_axis_tvalid <= 1'b0;
					while (board.pending() != 0)
						@(posedge clk);
				end
				send_pixel(random_pixel());
			end
		end
		idle_en = 1'b1;

		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (board.errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

>>> files.f
src/hsck_pkg.sv
src/hsck_front.sv
src/hsck_fifo.sv
src/hsck_back.sv
src/hue_saturation_color_key_top.sv
src/hsck_checker.sv
tb/tb.sv
